### rtl/link_registration_keepalive_fsm_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the link registration keepalive controller
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LINK_REGISTRATION_KEEPALIVE_FSM_ASSERT_SVH
`define LINK_REGISTRATION_KEEPALIVE_FSM_ASSERT_SVH

// Same-cycle implication.
`define LRK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LRK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lrk_pkg.sv
// ----------------------------------------------------------------------------
// lrk_pkg
// Types, codes and reset values of the link registration keepalive controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrk_pkg;

  localparam int unsigned CfgW  = 20;
  localparam int unsigned TimeW = 32;

  localparam logic [CfgW-1:0] RETRY_RESET    = CfgW'(5000);
  localparam logic [CfgW-1:0] HB_INT_RESET   = CfgW'(10000);
  localparam logic [CfgW-1:0] HB_ACK_TO_RESET = CfgW'(5000);

  // Configuration register indexes
  localparam logic [1:0] CFG_RETRY     = 2'd0;
  localparam logic [1:0] CFG_HB_INT    = 2'd1;
  localparam logic [1:0] CFG_HB_ACK_TO = 2'd2;

  // Event codes
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_ACK   = 3'd1;
  localparam logic [2:0] FUNC_NACK  = 3'd2;
  localparam logic [2:0] FUNC_DATA  = 3'd3;
  localparam logic [2:0] FUNC_CMD   = 3'd4;
  localparam logic [2:0] FUNC_DEREG = 3'd5;

  // Transmit codes
  localparam logic [2:0] SEND_NONE  = 3'd0;
  localparam logic [2:0] SEND_REG   = 3'd1;
  localparam logic [2:0] SEND_HB    = 3'd2;
  localparam logic [2:0] SEND_ACK   = 3'd3;
  localparam logic [2:0] SEND_DEREG = 3'd4;

  // Delivery codes
  localparam logic [1:0] DLV_NONE = 2'd0;
  localparam logic [1:0] DLV_DATA = 2'd1;
  localparam logic [1:0] DLV_CMD  = 2'd2;

  // Link state codes as seen on the result word
  localparam logic [1:0] LINK_DISC  = 2'd0;
  localparam logic [1:0] LINK_REGING = 2'd1;
  localparam logic [1:0] LINK_REGED = 2'd2;

  typedef enum logic [2:0] {
    CONN_DISC  = 3'b001,
    CONN_REGING = 3'b010,
    CONN_REGED = 3'b100
  } conn_state_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] msg_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       send_kind;
    logic [TimeW-1:0] send_id;
    logic [1:0]       deliver;
    logic [1:0]       link_state;
    logic             is_registered;
  } out_word_t;

  function automatic logic [1:0] link_code(conn_state_e st);
    logic [1:0] code;
    unique case (st)
      CONN_DISC:   code = LINK_DISC;
      CONN_REGING: code = LINK_REGING;
      CONN_REGED:  code = LINK_REGED;
      default:     code = LINK_DISC;
    endcase
    return code;
  endfunction

endpackage

### rtl/link_registration_keepalive_fsm.sv
// ----------------------------------------------------------------------------
// link_registration_keepalive_fsm
// Device-side registration and heartbeat controller with timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) carries one event word:
//   a tick, ack, nack, data, command or deregister request, stamped with the
//   current millisecond time. Every event yields exactly one result word on
//   the output channel (out_valid_o / out_ready_i / out_word_o): the message
//   to transmit, the payload delivery and the link state after the event.
//   The event word is held in the input register, then its result word loads
//   the result register, from which the receiver takes it. Throughput is one
//   word per cycle while the receiver does not stall; the single state update
//   between the two registers sets that rate.
//   When the receiver stalls, the result register holds, the input register
//   fills behind it, and in_ready_o drops only once both are occupied.
//   Reset empties both registers, puts the link in disconnected with all
//   times and ids at zero, and loads the interval registers with their
//   defaults (5000, 10000 and 5000 ms). Interval registers are written
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i, by the user only while no
//   event is in flight (the block does not enforce this); unknown indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_registration_keepalive_fsm
  import lrk_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // event words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o
);

  `include "link_registration_keepalive_fsm_assert.svh"

  // Interval registers
  logic [CfgW-1:0] retry_q, hb_int_q, hb_ack_to_q;

  // Pipeline registers
  logic      in_valid_q;
  in_word_t  in_q;
  logic      out_valid_q;
  out_word_t out_q;

  // Link state
  conn_state_e      conn_q, conn_d;
  logic             reg_flag_q, reg_flag_d;
  logic             await_hb_q, await_hb_d;
  logic [TimeW-1:0] last_att_q, last_att_d;
  logic [TimeW-1:0] last_hb_q, last_hb_d;
  logic [TimeW-1:0] reg_id_q, reg_id_d;
  logic [TimeW-1:0] hb_id_q, hb_id_d;

  logic             advance;
  logic [TimeW-1:0] el_att, el_hb;
  out_word_t        res_d;

  // Advance the held event into the result register when that register is
  // free or being emptied this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Wrapping elapsed times since the last attempt and the last heartbeat
  assign el_att = in_q.now_ms - last_att_q;
  assign el_hb  = in_q.now_ms - last_hb_q;

  always_comb begin
    conn_d        = conn_q;
    reg_flag_d    = reg_flag_q;
    await_hb_d    = await_hb_q;
    last_att_d    = last_att_q;
    last_hb_d     = last_hb_q;
    reg_id_d      = reg_id_q;
    hb_id_d       = hb_id_q;
    res_d.send_kind = SEND_NONE;
    res_d.send_id   = '0;
    res_d.deliver   = DLV_NONE;

    unique case (in_q.func)
      FUNC_TICK: begin
        unique case (conn_q)
          CONN_DISC: begin
            // Retry registration once the retry interval has run out
            if (el_att >= TimeW'(retry_q)) begin
              res_d.send_kind = SEND_REG;
              res_d.send_id   = in_q.now_ms;
              reg_id_d        = in_q.now_ms;
              last_att_d      = in_q.now_ms;
              conn_d          = CONN_REGING;
            end
          end
          CONN_REGING: begin
            // Registration ack never came: give up
            if (el_att >= TimeW'(retry_q)) begin
              conn_d = CONN_DISC;
            end
          end
          CONN_REGED: begin
            if (await_hb_q) begin
              // Heartbeat ack overdue: drop the link
              if (el_hb >= TimeW'(hb_ack_to_q)) begin
                conn_d     = CONN_DISC;
                reg_flag_d = 1'b0;
                await_hb_d = 1'b0;
              end
            end else if (el_hb >= TimeW'(hb_int_q)) begin
              res_d.send_kind = SEND_HB;
              res_d.send_id   = in_q.now_ms;
              await_hb_d      = 1'b1;
              last_hb_d       = in_q.now_ms;
              hb_id_d         = in_q.now_ms;
            end
          end
          default: ;
        endcase
      end
      FUNC_ACK: begin
        if (conn_q == CONN_REGING && in_q.msg_id == reg_id_q) begin
          conn_d     = CONN_REGED;
          reg_flag_d = 1'b1;
          await_hb_d = 1'b0;
        end else if (await_hb_q && in_q.msg_id == hb_id_q) begin
          await_hb_d = 1'b0;
        end
      end
      FUNC_NACK: begin
        conn_d     = CONN_DISC;
        reg_flag_d = 1'b0;
      end
      FUNC_DATA: begin
        // Echo the id back and hand the payload up
        res_d.deliver   = DLV_DATA;
        res_d.send_kind = SEND_ACK;
        res_d.send_id   = in_q.msg_id;
      end
      FUNC_CMD: begin
        res_d.deliver = DLV_CMD;
      end
      FUNC_DEREG: begin
        res_d.send_kind = SEND_DEREG;
        res_d.send_id   = in_q.now_ms;
        reg_flag_d      = 1'b0;
      end
      default: ;
    endcase

    res_d.link_state    = link_code(conn_d);
    res_d.is_registered = reg_flag_d;
  end

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q     <= RETRY_RESET;
      hb_int_q    <= HB_INT_RESET;
      hb_ack_to_q <= HB_ACK_TO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RETRY:     retry_q     <= cfg_wdata_i;
        CFG_HB_INT:    hb_int_q    <= cfg_wdata_i;
        CFG_HB_ACK_TO: hb_ack_to_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control: valid flags and link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      conn_q      <= CONN_DISC;
      reg_flag_q  <= 1'b0;
      await_hb_q  <= 1'b0;
      last_att_q  <= '0;
      last_hb_q   <= '0;
      reg_id_q    <= '0;
      hb_id_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        conn_q      <= conn_d;
        reg_flag_q  <= reg_flag_d;
        await_hb_q  <= await_hb_d;
        last_att_q  <= last_att_d;
        last_hb_q   <= last_hb_d;
        reg_id_q    <= reg_id_d;
        hb_id_q     <= hb_id_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  `LRK_ASSERT_SAME(a_flag_only_when_reged, reg_flag_q, conn_q == CONN_REGED,
    "registered flag set outside the registered state")
  `LRK_ASSERT_NEXT(a_advance_fills_result, advance, out_valid_q,
    "advanced event left no result word")
  `LRK_ASSERT_SAME(a_hb_when_reged, out_valid_q && out_q.send_kind == SEND_HB,
    out_q.link_state == LINK_REGED, "heartbeat sent outside registered state")
  `LRK_ASSERT_SAME(a_reg_enters_reging, out_valid_q && out_q.send_kind == SEND_REG,
    out_q.link_state == LINK_REGING, "registration sent without entering registering")

endmodule

### tb/sv/link_registration_keepalive_fsm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_registration_keepalive_fsm_tb
// Self-checking bench for the registration and heartbeat controller. A
// scoreboard class tracks link state, ids and intervals in step with the
// block and predicts one result word per accepted event word. Directed
// events cover the boundaries and every event kind. Random, state-aware
// traffic follows, run under several interval settings and handshake
// idle patterns.
// ----------------------------------------------------------------------------

import lrk_pkg::*;

class keepalive_scoreboard;
  logic [CfgW-1:0] retry_iv;
  logic [CfgW-1:0] hb_iv;
  logic [CfgW-1:0] hb_ack_to;
  logic [1:0]      link;
  logic            registered;
  logic            hb_wait;
  logic [31:0]     attempt_t;
  logic [31:0]     hb_sent_t;
  logic [31:0]     reg_id;
  logic [31:0]     hb_id;
  out_word_t       expected_q[$];
  int unsigned     errors;

  function new();
    retry_iv   = RETRY_RESET;
    hb_iv      = HB_INT_RESET;
    hb_ack_to  = HB_ACK_TO_RESET;
    link       = LINK_DISC;
    registered = 1'b0;
    hb_wait    = 1'b0;
    attempt_t  = '0;
    hb_sent_t  = '0;
    reg_id     = '0;
    hb_id      = '0;
    errors     = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [CfgW-1:0] val);
    case (idx)
      CFG_RETRY:     retry_iv = val;
      CFG_HB_INT:    hb_iv = val;
      CFG_HB_ACK_TO: hb_ack_to = val;
      default: ;
    endcase
  endfunction

  // Advance the link state by one event and queue the result word it yields.
  function void note_event(in_word_t w);
    out_word_t   r;
    logic [31:0] elapsed;
    r = '0;
    r.send_kind = SEND_NONE;
    r.deliver   = DLV_NONE;
    case (w.func)
      FUNC_TICK: begin
        if (link == LINK_DISC) begin
          elapsed = w.now_ms - attempt_t;
          if (elapsed >= 32'(retry_iv)) begin
            r.send_kind = SEND_REG;
            r.send_id   = w.now_ms;
            reg_id      = w.now_ms;
            attempt_t   = w.now_ms;
            link        = LINK_REGING;
          end
        end else if (link == LINK_REGING) begin
          elapsed = w.now_ms - attempt_t;
          if (elapsed >= 32'(retry_iv)) link = LINK_DISC;
        end else if (link == LINK_REGED) begin
          elapsed = w.now_ms - hb_sent_t;
          if (hb_wait) begin
            if (elapsed >= 32'(hb_ack_to)) begin
              link       = LINK_DISC;
              registered = 1'b0;
              hb_wait    = 1'b0;
            end
          end else if (elapsed >= 32'(hb_iv)) begin
            r.send_kind = SEND_HB;
            r.send_id   = w.now_ms;
            hb_wait     = 1'b1;
            hb_sent_t   = w.now_ms;
            hb_id       = w.now_ms;
          end
        end
      end
      FUNC_ACK: begin
        if (link == LINK_REGING && w.msg_id == reg_id) begin
          link       = LINK_REGED;
          registered = 1'b1;
          hb_wait    = 1'b0;
        end else if (hb_wait && w.msg_id == hb_id) begin
          hb_wait = 1'b0;
        end
      end
      FUNC_NACK: begin
        link       = LINK_DISC;
        registered = 1'b0;
      end
      FUNC_DATA: begin
        r.deliver   = DLV_DATA;
        r.send_kind = SEND_ACK;
        r.send_id   = w.msg_id;
      end
      FUNC_CMD: r.deliver = DLV_CMD;
      FUNC_DEREG: begin
        r.send_kind = SEND_DEREG;
        r.send_id   = w.now_ms;
        registered  = 1'b0;
      end
      default: ;
    endcase
    r.link_state    = link;
    r.is_registered = registered;
    expected_q.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  task check_result(out_word_t got);
    out_word_t want;
    if (expected_q.size() == 0) begin
      report("result word with nothing outstanding", 32'(got.send_kind), '0);
      return;
    end
    want = expected_q.pop_front();
    if (got.send_kind !== want.send_kind) begin
      report("send_kind", 32'(got.send_kind), 32'(want.send_kind));
    end
    if (got.send_id !== want.send_id) report("send_id", got.send_id, want.send_id);
    if (got.deliver !== want.deliver) begin
      report("deliver", 32'(got.deliver), 32'(want.deliver));
    end
    if (got.link_state !== want.link_state) begin
      report("link_state", 32'(got.link_state), 32'(want.link_state));
    end
    if (got.is_registered !== want.is_registered) begin
      report("is_registered", 32'(got.is_registered), 32'(want.is_registered));
    end
  endtask
endclass

module link_registration_keepalive_fsm_tb;

  localparam int unsigned WordsPerPhase = 180;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldCycles    = 200;
  // Index that maps to no interval register; writes to it must be dropped.
  localparam logic [1:0]  CfgUnused     = 2'd3;
  localparam logic [2:0]  FuncSpare6    = 3'd6;
  localparam logic [2:0]  FuncSpare7    = 3'd7;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_ready_o;
  in_word_t        in_word_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_word_t       out_word_o;

  keepalive_scoreboard sb;

  // Handshake pressure knobs, percent of cycles spent idle on each side.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // Set by the stimulus, counted down by the receiver process.
  int unsigned rx_hold_cycles;
  int unsigned cycle_count = 0;
  // Time stamp of the last event offered, the base for the next one.
  logic [31:0] clock_ms;

  link_registration_keepalive_fsm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: stall at random, or hold off completely while a hold is pending.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Check every result word taken at an edge; values read here are pre-edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_word_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one event word, hold it until taken, then maybe idle a while.
  // Keep valid high across back-to-back words so it is never dropped and
  // raised in the same step.
  task automatic send_event(logic [2:0] func, logic [31:0] now, logic [31:0] id);
    in_word_t w;
    w.func   = func;
    w.now_ms = now;
    w.msg_id = id;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_event(w);
    clock_ms = now;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  // Stop offering, wait for every outstanding result, then let the pipe settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic set_intervals(logic [CfgW-1:0] retry, logic [CfgW-1:0] hb,
                               logic [CfgW-1:0] ack_to);
    write_reg(CFG_RETRY, retry);
    write_reg(CFG_HB_INT, hb);
    write_reg(CFG_HB_ACK_TO, ack_to);
    cfg_we_i <= 1'b0;
  endtask

  // Pick a tick time that often lands on or next to the deadline that matters
  // in the current state, so the >= compares are hit from both sides.
  function automatic logic [31:0] next_tick_time();
    logic [31:0] anchor;
    logic [31:0] span;
    if (sb.link == LINK_REGED) begin
      anchor = sb.hb_sent_t;
      span   = sb.hb_wait ? 32'(sb.hb_ack_to) : 32'(sb.hb_iv);
    end else begin
      anchor = sb.attempt_t;
      span   = 32'(sb.retry_iv);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return anchor + span + $urandom_range(0, 2) - 1;
      4, 5, 6:    return clock_ms + $urandom_range(0, span / 3 + 1);
      7:          return clock_ms;
      8:          return $urandom;
      default:    return anchor + $urandom_range(0, span);
    endcase
  endfunction

  // Mostly well-formed traffic: ticks and acks that echo the outstanding id,
  // mixed with stray acks, nacks, payloads, deregisters and unused codes.
  task automatic run_random(int unsigned count);
    int unsigned  pick;
    logic [2:0]   func;
    logic [31:0]  now;
    logic [31:0]  id;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      now  = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms + $urandom_range(0, 3);
      id   = $urandom;
      if (pick < 45) begin
        func = FUNC_TICK;
        now  = next_tick_time();
      end else if (pick < 70) begin
        func = FUNC_ACK;
        case ($urandom_range(0, 5))
          0, 1, 2: id = (sb.link == LINK_REGING) ? sb.reg_id : sb.hb_id;
          3:       id = sb.reg_id;
          4:       id = sb.hb_id + $urandom_range(0, 2) - 1;
          default: ;
        endcase
      end else if (pick < 75) begin
        func = FUNC_NACK;
      end else if (pick < 84) begin
        func = FUNC_DATA;
      end else if (pick < 91) begin
        func = FUNC_CMD;
      end else if (pick < 96) begin
        func = FUNC_DEREG;
      end else begin
        func = $urandom_range(0, 1) ? FuncSpare7 : FuncSpare6;
      end
      send_event(func, now, id);
    end
  endtask

  // Walk the reset intervals (retry 5000, heartbeat 10000, ack wait 5000)
  // through every state and edge case.
  task automatic run_directed();
    send_event(FUNC_TICK, 32'd0, 32'd0);             // too early, stay disconnected
    send_event(FUNC_TICK, 32'd4999, 32'd0);          // one short of the retry
    send_event(FUNC_TICK, 32'd5000, 32'd0);          // register, id 5000
    send_event(FUNC_ACK, 32'd5001, 32'd4999);        // wrong id, ignore
    send_event(FUNC_ACK, 32'd5002, 32'd5000);        // registered
    send_event(FUNC_TICK, 32'd9999, 32'd0);          // heartbeat not due yet
    send_event(FUNC_TICK, 32'd10000, 32'd0);         // heartbeat, id 10000
    send_event(FUNC_TICK, 32'd14999, 32'd0);         // ack wait not over
    send_event(FUNC_ACK, 32'd15000, 32'd10000);      // heartbeat acked
    send_event(FUNC_TICK, 32'd20000, 32'd0);         // next heartbeat
    send_event(FUNC_TICK, 32'd25000, 32'd0);         // no ack: drop the link
    send_event(FUNC_DATA, 32'd25001, 32'hFFFF_FFFF); // echo ack, deliver data
    send_event(FUNC_CMD, 32'd25002, 32'h0000_0000);  // deliver command
    send_event(FUNC_DEREG, 32'hFFFF_FFFF, 32'd0);    // deregister at max time
    send_event(FuncSpare6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(FuncSpare7, 32'h0, 32'h0);
    send_event(FUNC_TICK, 32'hFFFF_FFFF, 32'd0);     // register, id all ones
    send_event(FUNC_TICK, 32'd4095, 32'd0);          // wrapped, still waiting
    send_event(FUNC_TICK, 32'd4999, 32'd0);          // wrapped retry: give up
    send_event(FUNC_TICK, 32'd10000, 32'd0);         // register again
    send_event(FUNC_ACK, 32'd10001, 32'd10000);      // registered
    send_event(FUNC_DEREG, 32'd10002, 32'd0);        // flag clears, state holds
    send_event(FUNC_ACK, 32'd10003, 32'd10000);      // stale ack, ignore
    send_event(FUNC_NACK, 32'd10004, 32'd0);         // back to disconnected
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_RETRY;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    tx_idle_pct    = 31;
    rx_idle_pct    = 68;
    rx_hold_cycles = 0;
    clock_ms       = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles lightly, receiver heavily.
    run_directed();
    drain_results();
    write_reg(CfgUnused, CfgW'($urandom));
    cfg_we_i <= 1'b0;
    run_random(WordsPerPhase);
    drain_results();

    // Short intervals; pause the sender mid-phase until all results are back.
    set_intervals(CfgW'($urandom_range(1, 64)), CfgW'($urandom_range(1, 64)),
                  CfgW'($urandom_range(1, 64)));
    run_random(WordsPerPhase / 2);
    drain_results();
    run_random(WordsPerPhase / 2);
    drain_results();

    // Swap the idle pattern: sender heavy, receiver light.
    tx_idle_pct = 68;
    rx_idle_pct = 31;
    set_intervals('0, '0, '0);
    run_random(WordsPerPhase);
    drain_results();
    set_intervals('1, '1, '1);
    run_random(WordsPerPhase);
    drain_results();

    // No idling; hold the receiver off so the block backs up and stalls input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_intervals(CfgW'($urandom_range(0, 3000)), CfgW'($urandom_range(0, 3000)),
                  CfgW'($urandom_range(0, 3000)));
    rx_hold_cycles = HoldCycles;
    run_random(WordsPerPhase);
    drain_results();
    set_intervals(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
    run_random(WordsPerPhase);
    drain_results();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lrk_pkg.sv
rtl/link_registration_keepalive_fsm.sv
tb/sv/link_registration_keepalive_fsm_tb.sv
